// File: rtl/core/spr_pkg.sv
// ----------------------------------------------------------------------------
// Servo record/playback package
// Shared widths, constants, codes, stage types and scaling functions.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Default number of record slots.
  localparam int unsigned SLOTS_DEF = 10;

  // Field widths.
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned ANGLE_W    = 7;
  localparam int unsigned CMP_W      = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned BASE_W     = 15;
  localparam int unsigned SPAN_W     = 15;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PROD_W     = DUTY_W + SPAN_W;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = PERIOD_W'(2000);
  localparam logic [BASE_W-1:0]   PWM_BASE_RST    = BASE_W'(1875);
  localparam logic [SPAN_W-1:0]   PWM_SPAN_RST    = SPAN_W'(1875);

  // Division by 255 as multiplication by a rounded-up reciprocal.
  // Exact for products below 2^23: 127 * 2^23 < 2^31.
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 31;
  localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'(8421505);

  // Angle is floor(duty * 6 / 17); 1446 / 4096 rounds 6/17 up, exact for 8-bit duty.
  localparam int unsigned ANGLE_PROD_W = 19;
  localparam int unsigned ANGLE_SHIFT  = 12;
  localparam logic [ANGLE_PROD_W-1:0] ANGLE_MUL = ANGLE_PROD_W'(1446);

  // Sequencer modes.
  typedef enum logic [4:0] {
    MODE_PROGRAM = 5'b00001,
    MODE_RUN     = 5'b00010,
    MODE_STOP    = 5'b00100,
    MODE_RESET   = 5'b01000,
    MODE_TEST    = 5'b10000
  } mode_e;

  // Mode code reported with each result.
  typedef enum logic [CODE_W-1:0] {
    CODE_PROGRAM = 2'd0,
    CODE_RUN     = 2'd1,
    CODE_STOP    = 2'd2,
    CODE_TEST    = 2'd3
  } code_e;

  // Display update requested by the sequencer.
  typedef enum logic [1:0] {
    DISP_HOLD      = 2'd0,
    DISP_SHOW_MEM  = 2'd1,
    DISP_SHOW_DUTY = 2'd2,
    DISP_CLEAR     = 2'd3
  } disp_op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD = 2'd0,
    CFG_PWM_BASE    = 2'd1,
    CFG_PWM_SPAN    = 2'd2
  } cfg_idx_e;

  // Slot memory command.
  typedef struct packed {
    logic we;
    logic clr;
    logic re;
  } mem_cmd_t;

  // One item after the sequencer stage.
  typedef struct packed {
    logic              valid;
    code_e             code;
    disp_op_e          op;
    logic [SLOT_W-1:0] slot;
    logic [DUTY_W-1:0] duty;
    logic              rd_ok;
    logic              written;
  } stage_t;

  // Display angle of a duty value.
  function automatic logic [ANGLE_W-1:0] angle_of(input logic [DUTY_W-1:0] duty);
    logic [ANGLE_PROD_W-1:0] p;
    p = ANGLE_PROD_W'(duty) * ANGLE_MUL;
    return ANGLE_W'(p >> ANGLE_SHIFT);
  endfunction

  // floor(prod / 255) for a duty times span product.
  function automatic logic [SPAN_W-1:0] scale_of(input logic [PROD_W-1:0] prod);
    logic [PROD_W+RECIP_W-1:0] p;
    p = (PROD_W+RECIP_W)'(prod) * (PROD_W+RECIP_W)'(RECIP_255);
    return SPAN_W'(p >> RECIP_SHIFT);
  endfunction

endpackage

// File: rtl/core/spr_slot_mem.sv
// ----------------------------------------------------------------------------
// Servo record/playback slot memory
// Synchronous slot store with one write and one registered read port, and
// per-entry valid bits so that clearing the whole store resets only those bits.
// ----------------------------------------------------------------------------
module spr_slot_mem #(
  parameter int unsigned SLOTS = spr_pkg::SLOTS_DEF,
  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spr_pkg::mem_cmd_t         cmd_i,
  input  logic [ADDR_W-1:0]         wr_addr_i,
  input  logic [spr_pkg::DUTY_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]         rd_addr_i,
  output logic [spr_pkg::DUTY_W-1:0] rdata_o,
  output logic                      rvalid_o
);

  logic [spr_pkg::DUTY_W-1:0] mem_q [SLOTS];
  logic [spr_pkg::DUTY_W-1:0] rdata_q;
  logic [SLOTS-1:0]           valid_q;
  logic                       rvalid_q;

  // Data array and registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[wr_addr_i] <= wdata_i;
    end
    if (cmd_i.re) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: an entry that was never written since the last clear reads with rvalid_o low.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        valid_q <= '0;
      end else if (cmd_i.we) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.re) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

// File: rtl/core/spr_ctrl.sv
// ----------------------------------------------------------------------------
// Servo record/playback sequencer
// Mode machine, record and replay indices and the step timer. Each accepted
// tick updates this state and issues the slot memory access for the item.
// ----------------------------------------------------------------------------
module spr_ctrl #(
  parameter int unsigned SLOTS = spr_pkg::SLOTS_DEF,
  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [spr_pkg::DUTY_W-1:0]    duty_sample_i,
  input  logic                          stop_button_i,
  input  logic                          run_button_i,
  input  logic                          clear_button_i,
  input  logic                          set_button_i,
  input  logic                          test_button_i,
  input  logic [spr_pkg::PERIOD_W-1:0]  step_period_i,
  input  logic                          take_i,
  output spr_pkg::stage_t               stage_o,
  output spr_pkg::mem_cmd_t             mem_cmd_o,
  output logic [ADDR_W-1:0]             mem_wr_addr_o,
  output logic [spr_pkg::DUTY_W-1:0]    mem_wdata_o,
  output logic [ADDR_W-1:0]             mem_rd_addr_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS);

  spr_pkg::mode_e               mode_q, mode_d;
  logic [IDX_W-1:0]             rec_pos_q, rec_pos_d;
  logic [IDX_W-1:0]             rec_cnt_q, rec_cnt_d;
  logic [IDX_W-1:0]             replay_q, replay_d;
  logic [IDX_W-1:0]             test_q, test_d;
  logic [spr_pkg::PERIOD_W-1:0] tick_q, tick_d;
  logic                         set_rel_q, set_rel_d;
  spr_pkg::stage_t              s1_q, s1_d;

  logic                         accept;
  logic [spr_pkg::PERIOD_W-1:0] tick_inc;
  logic [spr_pkg::PERIOD_W-1:0] tick_nx;
  logic                         step;
  logic [IDX_W-1:0]             pos_nx;
  logic                         show;
  logic [IDX_W-1:0]             show_idx;
  spr_pkg::mem_cmd_t            cmd;

  // The stage register frees up whenever the datapath takes its item.
  assign in_stall_o = s1_q.valid & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Shared step timer for run and test replay.
  assign tick_inc = tick_q + spr_pkg::PERIOD_W'(1);
  assign step     = (tick_inc >= step_period_i);
  assign tick_nx  = step ? '0 : tick_inc;

  // Next state for one tick.
  always_comb begin
    mode_d    = mode_q;
    rec_pos_d = rec_pos_q;
    rec_cnt_d = rec_cnt_q;
    replay_d  = replay_q;
    test_d    = test_q;
    tick_d    = tick_q;
    set_rel_d = set_rel_q;
    pos_nx    = '0;
    show      = 1'b0;
    show_idx  = '0;
    cmd       = '0;

    s1_d         = '0;
    s1_d.valid   = 1'b1;
    s1_d.code    = spr_pkg::CODE_PROGRAM;
    s1_d.op      = spr_pkg::DISP_HOLD;
    s1_d.duty    = duty_sample_i;

    case (mode_q)
      spr_pkg::MODE_PROGRAM: begin
        replay_d = '0;
        test_d   = '0;
        // Record on a fresh press while free slots remain.
        if (set_button_i && (rec_pos_q < LAST_IDX) && set_rel_q) begin
          set_rel_d = 1'b0;
          cmd.we    = 1'b1;
          s1_d.op   = spr_pkg::DISP_SHOW_DUTY;
          s1_d.slot = spr_pkg::SLOT_W'(rec_pos_q);
          rec_pos_d = rec_pos_q + IDX_W'(1);
        end
        if (!set_button_i) begin
          set_rel_d = 1'b1;
        end
        if (clear_button_i) begin
          mode_d = spr_pkg::MODE_RESET;
        end else if (test_button_i) begin
          mode_d = spr_pkg::MODE_TEST;
        end else if (run_button_i) begin
          mode_d = spr_pkg::MODE_RUN;
        end
        // The record count is latched as program mode is left.
        if (clear_button_i || test_button_i || run_button_i) begin
          rec_cnt_d = rec_pos_d;
        end
      end
      spr_pkg::MODE_RUN: begin
        s1_d.code = spr_pkg::CODE_RUN;
        rec_pos_d = '0;
        test_d    = '0;
        tick_d    = tick_nx;
        pos_nx    = replay_q;
        if (step) begin
          show         = 1'b1;
          show_idx     = replay_q;
          s1_d.written = 1'b1;
          pos_nx       = replay_q + IDX_W'(1);
        end
        replay_d = (pos_nx >= rec_cnt_q) ? '0 : pos_nx;
        if (stop_button_i) begin
          mode_d = spr_pkg::MODE_STOP;
        end else if (clear_button_i) begin
          mode_d = spr_pkg::MODE_RESET;
        end
      end
      spr_pkg::MODE_STOP: begin
        s1_d.code = spr_pkg::CODE_STOP;
        show      = 1'b1;
        show_idx  = replay_q;
        if (run_button_i) begin
          mode_d = spr_pkg::MODE_RUN;
        end
      end
      spr_pkg::MODE_TEST: begin
        s1_d.code = spr_pkg::CODE_TEST;
        replay_d  = '0;
        rec_pos_d = '0;
        tick_d    = tick_nx;
        pos_nx    = test_q;
        if (step) begin
          show     = 1'b1;
          show_idx = test_q;
          pos_nx   = test_q + IDX_W'(1);
        end
        test_d = ((pos_nx >= rec_cnt_q) || test_button_i) ? '0 : pos_nx;
        if (clear_button_i) begin
          mode_d = spr_pkg::MODE_RESET;
        end else if (run_button_i) begin
          mode_d = spr_pkg::MODE_RUN;
        end
      end
      default: begin
        // Reset mode: wipe the store and the record and replay indices, back to program.
        s1_d.op   = spr_pkg::DISP_CLEAR;
        cmd.clr   = 1'b1;
        rec_pos_d = '0;
        rec_cnt_d = '0;
        replay_d  = '0;
        mode_d    = spr_pkg::MODE_PROGRAM;
      end
    endcase

    // Slot display read; an index past the store shows duty zero.
    if (show) begin
      s1_d.op    = spr_pkg::DISP_SHOW_MEM;
      s1_d.slot  = spr_pkg::SLOT_W'(show_idx);
      s1_d.rd_ok = (show_idx < LAST_IDX);
      cmd.re     = s1_d.rd_ok;
    end
  end

  // Memory access happens at the transfer edge of the item.
  assign mem_cmd_o.we   = cmd.we & accept;
  assign mem_cmd_o.clr  = cmd.clr & accept;
  assign mem_cmd_o.re   = cmd.re & accept;
  assign mem_wr_addr_o  = ADDR_W'(rec_pos_q);
  assign mem_wdata_o    = duty_sample_i;
  assign mem_rd_addr_o  = ADDR_W'(show_idx);

  // Sequencer state and stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= spr_pkg::MODE_PROGRAM;
      rec_pos_q <= '0;
      rec_cnt_q <= '0;
      replay_q  <= '0;
      test_q    <= '0;
      tick_q    <= '0;
      set_rel_q <= 1'b1;
      s1_q      <= '0;
    end else begin
      if (accept) begin
        mode_q    <= mode_d;
        rec_pos_q <= rec_pos_d;
        rec_cnt_q <= rec_cnt_d;
        replay_q  <= replay_d;
        test_q    <= test_d;
        tick_q    <= tick_d;
        set_rel_q <= set_rel_d;
        s1_q      <= s1_d;
      end else if (take_i) begin
        s1_q.valid <= 1'b0;
      end
    end
  end

  assign stage_o = s1_q;

endmodule

// File: rtl/core/spr_datapath.sv
// ----------------------------------------------------------------------------
// Servo record/playback datapath
// Takes the slot read data, updates the held display, forms duty times span,
// then, for a written item, scales by 1/255, adds the base and holds the result for the output.
// ----------------------------------------------------------------------------
module spr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spr_pkg::stage_t               stage_i,
  output logic                          take_o,
  input  logic [spr_pkg::DUTY_W-1:0]    rdata_i,
  input  logic                          rvalid_i,
  input  logic [spr_pkg::BASE_W-1:0]    pwm_base_i,
  input  logic [spr_pkg::SPAN_W-1:0]    pwm_span_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spr_pkg::CODE_W-1:0]    mode_code_o,
  output logic [spr_pkg::SLOT_W-1:0]    shown_slot_o,
  output logic [spr_pkg::ANGLE_W-1:0]   shown_angle_o,
  output logic [spr_pkg::CMP_W-1:0]     pwm_compare_o,
  output logic                          pwm_written_o
);

  logic                          en2, en3, move;
  logic [spr_pkg::DUTY_W-1:0]    duty_sel;
  logic [spr_pkg::SLOT_W-1:0]    slot_nx;
  logic [spr_pkg::ANGLE_W-1:0]   angle_nx;

  // Held display state.
  logic [spr_pkg::SLOT_W-1:0]    disp_slot_q;
  logic [spr_pkg::ANGLE_W-1:0]   disp_angle_q;

  // Product stage.
  logic                          v2_q;
  spr_pkg::code_e                code2_q;
  logic [spr_pkg::SLOT_W-1:0]    slot2_q;
  logic [spr_pkg::ANGLE_W-1:0]   angle2_q;
  logic                          wr2_q;
  logic [spr_pkg::PROD_W-1:0]    prod2_q;

  // Output register.
  logic                          v3_q;
  spr_pkg::code_e                code3_q;
  logic [spr_pkg::SLOT_W-1:0]    slot3_q;
  logic [spr_pkg::ANGLE_W-1:0]   angle3_q;
  logic                          wr3_q;
  logic [spr_pkg::CMP_W-1:0]     cmp_q;

  // Stage enables: a stage moves when the one after it is empty or moving.
  assign en3    = ~v3_q | ~out_stall_i;
  assign en2    = ~v2_q | en3;
  assign take_o = stage_i.valid & en2;
  assign move   = v2_q & en3;

  // Duty behind the display update.
  always_comb begin
    case (stage_i.op)
      spr_pkg::DISP_SHOW_MEM:  duty_sel = (stage_i.rd_ok & rvalid_i) ? rdata_i : '0;
      spr_pkg::DISP_SHOW_DUTY: duty_sel = stage_i.duty;
      default:                 duty_sel = '0;
    endcase
  end

  // Next held display.
  always_comb begin
    case (stage_i.op)
      spr_pkg::DISP_SHOW_MEM, spr_pkg::DISP_SHOW_DUTY: begin
        slot_nx  = stage_i.slot;
        angle_nx = spr_pkg::angle_of(duty_sel);
      end
      spr_pkg::DISP_CLEAR: begin
        slot_nx  = '0;
        angle_nx = '0;
      end
      default: begin
        slot_nx  = disp_slot_q;
        angle_nx = disp_angle_q;
      end
    endcase
  end

  // Control and held state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_slot_q  <= '0;
      disp_angle_q <= '0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      cmp_q        <= '0;
    end else begin
      if (take_o) begin
        disp_slot_q  <= slot_nx;
        disp_angle_q <= angle_nx;
        v2_q         <= 1'b1;
      end else if (en3) begin
        v2_q <= 1'b0;
      end
      if (move) begin
        v3_q <= 1'b1;
        if (wr2_q) begin
          cmp_q <= spr_pkg::CMP_W'(pwm_base_i)
                 + spr_pkg::CMP_W'(spr_pkg::scale_of(prod2_q));
        end
      end else if (!out_stall_i) begin
        v3_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      code2_q  <= stage_i.code;
      slot2_q  <= slot_nx;
      angle2_q <= angle_nx;
      wr2_q    <= stage_i.written;
      prod2_q  <= spr_pkg::PROD_W'(duty_sel) * spr_pkg::PROD_W'(pwm_span_i);
    end
    if (move) begin
      code3_q  <= code2_q;
      slot3_q  <= slot2_q;
      angle3_q <= angle2_q;
      wr3_q    <= wr2_q;
    end
  end

  assign out_valid_o   = v3_q;
  assign mode_code_o   = code3_q;
  assign shown_slot_o  = slot3_q;
  assign shown_angle_o = angle3_q;
  assign pwm_compare_o = cmp_q;
  assign pwm_written_o = wr3_q;

endmodule

// File: rtl/core/servo_position_record_playback.sv
// ----------------------------------------------------------------------------
// Servo position record and playback sequencer
// Teach-and-replay servo control stepped once per tick: records duty samples
// into slots and replays them as PWM compare values and display angles.
//
//   Channel  Direction  Handshake                 Payload
//   in       to block   in_valid_i / in_stall_o   duty_sample, five buttons
//   out      from block out_valid_o / out_stall_i mode_code, shown_slot,
//                                                 shown_angle, pwm_compare,
//                                                 pwm_written
//   cfg      to block   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One tick is taken every cycle while in_stall_o is low; each result passes
// three registered stages (sequencer and slot read, duty times span, scale
// by 1/255).
// The slot memory read latency and the two multiplies set that depth.
// Reset returns all state at once; the slot store clears through valid bits.
// Output stalls fill the three stages before in_stall_o rises.
// ----------------------------------------------------------------------------
module servo_position_record_playback #(
  parameter int unsigned SLOTS = spr_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [spr_pkg::DUTY_W-1:0]      duty_sample_i,
  input  logic                            stop_button_i,
  input  logic                            run_button_i,
  input  logic                            clear_button_i,
  input  logic                            set_button_i,
  input  logic                            test_button_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spr_pkg::CODE_W-1:0]      mode_code_o,
  output logic [spr_pkg::SLOT_W-1:0]      shown_slot_o,
  output logic [spr_pkg::ANGLE_W-1:0]     shown_angle_o,
  output logic [spr_pkg::CMP_W-1:0]       pwm_compare_o,
  output logic                            pwm_written_o,
  input  logic                            cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [spr_pkg::PERIOD_W-1:0] step_period_q;
  logic [spr_pkg::BASE_W-1:0]   pwm_base_q;
  logic [spr_pkg::SPAN_W-1:0]   pwm_span_q;

  spr_pkg::stage_t              stage;
  spr_pkg::mem_cmd_t            mem_cmd;
  logic [ADDR_W-1:0]            mem_wr_addr;
  logic [ADDR_W-1:0]            mem_rd_addr;
  logic [spr_pkg::DUTY_W-1:0]   mem_wdata;
  logic [spr_pkg::DUTY_W-1:0]   mem_rdata;
  logic                         mem_rvalid;
  logic                         take;

  // Configuration registers; an unknown index writes nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= spr_pkg::STEP_PERIOD_RST;
      pwm_base_q    <= spr_pkg::PWM_BASE_RST;
      pwm_span_q    <= spr_pkg::PWM_SPAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spr_pkg::CFG_STEP_PERIOD: step_period_q <= spr_pkg::PERIOD_W'(cfg_wdata_i);
        spr_pkg::CFG_PWM_BASE:    pwm_base_q    <= spr_pkg::BASE_W'(cfg_wdata_i);
        spr_pkg::CFG_PWM_SPAN:    pwm_span_q    <= spr_pkg::SPAN_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  spr_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .duty_sample_i  (duty_sample_i),
    .stop_button_i  (stop_button_i),
    .run_button_i   (run_button_i),
    .clear_button_i (clear_button_i),
    .set_button_i   (set_button_i),
    .test_button_i  (test_button_i),
    .step_period_i  (step_period_q),
    .take_i         (take),
    .stage_o        (stage),
    .mem_cmd_o      (mem_cmd),
    .mem_wr_addr_o  (mem_wr_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rd_addr_o  (mem_rd_addr)
  );

  spr_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mem_cmd),
    .wr_addr_i (mem_wr_addr),
    .wdata_i   (mem_wdata),
    .rd_addr_i (mem_rd_addr),
    .rdata_o   (mem_rdata),
    .rvalid_o  (mem_rvalid)
  );

  spr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .take_o        (take),
    .rdata_i       (mem_rdata),
    .rvalid_i      (mem_rvalid),
    .pwm_base_i    (pwm_base_q),
    .pwm_span_i    (pwm_span_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mode_code_o   (mode_code_o),
    .shown_slot_o  (shown_slot_o),
    .shown_angle_o (shown_angle_o),
    .pwm_compare_o (pwm_compare_o),
    .pwm_written_o (pwm_written_o)
  );

endmodule

// File: rtl/core/spr_checker.sv
// ----------------------------------------------------------------------------
// Servo record/playback port checker
// Watches the top-level ports for output hold, run-only writes, compare hold,
// angle range and the number of ticks in flight.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [spr_pkg::CODE_W-1:0]     mode_code_o,
  input logic [spr_pkg::SLOT_W-1:0]     shown_slot_o,
  input logic [spr_pkg::ANGLE_W-1:0]    shown_angle_o,
  input logic [spr_pkg::CMP_W-1:0]      pwm_compare_o,
  input logic                           pwm_written_o
);

  logic                       in_xfer, out_xfer;
  logic [2:0]                 inflight_q;
  logic [spr_pkg::CMP_W-1:0]  last_cmp_q;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_xfer = out_valid_o & ~out_stall_i;

  // Ticks transferred in whose results have not transferred out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      last_cmp_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
      if (out_xfer) begin
        last_cmp_q <= pwm_compare_o;
      end
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pwm_compare_o)
      && $stable(shown_slot_o) && $stable(shown_angle_o) && $stable(mode_code_o))
    else $error("output changed while stalled");

  // Only run mode writes the compare register.
  a_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pwm_written_o |-> mode_code_o == spr_pkg::CODE_RUN)
    else $error("compare written outside run mode");

  // Without a write the compare value carries over from the previous result.
  a_cmp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pwm_written_o |-> pwm_compare_o == last_cmp_q)
    else $error("compare changed without a write");

  // Display angle stays within a quarter turn.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shown_angle_o <= spr_pkg::ANGLE_W'(90))
    else $error("display angle out of range");

  // At most three ticks are in flight, and a valid result has a tick behind it.
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3 && (inflight_q != 3'd0 || !out_valid_o))
    else $error("result count does not match transferred ticks");

endmodule

bind servo_position_record_playback spr_checker u_spr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .mode_code_o   (mode_code_o),
  .shown_slot_o  (shown_slot_o),
  .shown_angle_o (shown_angle_o),
  .pwm_compare_o (pwm_compare_o),
  .pwm_written_o (pwm_written_o)
);
